// ===== rtl/tpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpmc_pkg
// Shared constants and types of the push message collector.
// ----------------------------------------------------------------------------
package tpmc_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int CNT_W     = BUF_AW + 1;
    localparam int LEN_W     = 16;
    localparam int SUM_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int SEQ_W     = 32;
    localparam int IDX_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 2;
    localparam int STATE_W   = 3;

    localparam logic [MODE_W-1:0] MODE_HEADER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    typedef enum logic [STATE_W-1:0] {
        PH_INVALID = 3'd0,
        PH_WAIT    = 3'd1,
        PH_SYNC    = 3'd2,
        PH_WORK    = 3'd3,
        PH_PUSHED  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [STATE_W-1:0] collector_state;
        logic               frame_accepted;
        logic               message_ready;
        logic [CNT_W-1:0]   message_length;
        logic               read_hit;
    } t_stage;

endpackage

// ===== rtl/tpmc_req_if.sv =====
// ----------------------------------------------------------------------------
// tpmc_req_if
// Request channel into the collector: header, payload byte or read.
// ----------------------------------------------------------------------------
interface tpmc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic        flag_fin;
    logic        flag_syn;
    logic        flag_rst;
    logic        flag_psh;
    logic        flag_ack;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic [11:0] read_index;

    modport source (
        output valid, mode, seq_number, ack_number, flag_fin, flag_syn, flag_rst,
               flag_psh, flag_ack, payload_length, data_byte, read_index,
        input  ready
    );
    modport sink (
        input  valid, mode, seq_number, ack_number, flag_fin, flag_syn, flag_rst,
               flag_psh, flag_ack, payload_length, data_byte, read_index,
        output ready
    );
endinterface

// ----------------------------------------------------------------------------
// tpmc_rsp_if
// Result channel out of the collector, one result per request.
// ----------------------------------------------------------------------------
interface tpmc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  collector_state;
    logic        frame_accepted;
    logic        message_ready;
    logic [12:0] message_length;
    logic [7:0]  read_byte;

    modport source (
        output valid, collector_state, frame_accepted, message_ready,
               message_length, read_byte,
        input  ready
    );
    modport sink (
        input  valid, collector_state, frame_accepted, message_ready,
               message_length, read_byte,
        output ready
    );
endinterface

// ===== rtl/tcp_push_message_collector_top.sv =====
// ----------------------------------------------------------------------------
// tcp_push_message_collector_top
// Collects a TCP byte stream into a message buffer and serves byte reads.
//
//   channel  dir  handshake        content
//   i_req    in   valid / ready    mode, header fields, data byte, read index
//   o_rsp    out  valid / ready    state, accepted, ready, length, read byte
//
// One request per cycle is taken while o_rsp accepts results; every request yields
// one result, through the message RAM read stage and then the output register.
// Header checks, the sequence add and the fill compare settle in the accept
// cycle; a payload byte writes the RAM in that cycle.
// Synchronous active-low reset clears phase and counters; RAM content is
// left as is. A stalled output holds the read stage, which then holds i_req.
// ----------------------------------------------------------------------------
module tcp_push_message_collector_top
    import tpmc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tpmc_req_if.sink     i_req,
    tpmc_rsp_if.source   o_rsp
);

    t_phase              r_phase,   n_phase;
    logic [CNT_W-1:0]    r_fill,    n_fill;
    logic [SEQ_W-1:0]    r_exp_seq, n_exp_seq;
    logic [SEQ_W-1:0]    r_exp_ack, n_exp_ack;
    logic [LEN_W-1:0]    r_pending, n_pending;
    logic                r_append,  n_append;

    logic                r_s1_valid;
    t_stage              r_s1;
    t_stage              n_s1;
    logic                r_out_valid;
    t_stage              r_out;
    logic [BYTE_W-1:0]   r_out_byte;

    logic                s1_adv;
    logic                in_ready;
    logic                accept;
    logic                accepted;
    logic                do_work;
    logic                work_fail;
    logic [SEQ_W-1:0]    eack;
    logic [SEQ_W-1:0]    seq_sum;
    logic [SUM_W-1:0]    fill_sum;
    logic                ram_we;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;

    assign s1_adv   = !r_out_valid || o_rsp.ready;
    assign in_ready = !r_s1_valid || s1_adv;
    assign accept   = i_req.valid && in_ready;

    assign i_req.ready = in_ready;

    assign eack     = (r_phase == PH_SYNC) ? i_req.ack_number : r_exp_ack;
    assign seq_sum  = i_req.seq_number + SEQ_W'(i_req.payload_length);
    assign fill_sum = SUM_W'(r_fill) + SUM_W'(i_req.payload_length);
    assign do_work  = (r_phase == PH_WORK) || (r_phase == PH_SYNC && i_req.flag_ack);
    assign work_fail = i_req.flag_fin || i_req.flag_rst || i_req.flag_syn
                    || (i_req.ack_number != eack)
                    || (i_req.seq_number != r_exp_seq)
                    || (fill_sum > SUM_W'(BUF_BYTES));

    always_comb begin
        n_phase   = r_phase;
        n_fill    = r_fill;
        n_exp_seq = r_exp_seq;
        n_exp_ack = r_exp_ack;
        n_pending = r_pending;
        n_append  = r_append;
        accepted  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (i_req.mode)
            MODE_HEADER: begin
                n_pending = i_req.payload_length;
                n_append  = 1'b0;
                if (r_phase == PH_SYNC && i_req.flag_ack) begin
                    n_exp_ack = i_req.ack_number;
                end
                if (do_work && !work_fail) begin
                    accepted = 1'b1;
                    n_append = (i_req.payload_length != '0);
                    if (i_req.flag_psh) begin
                        n_phase = PH_PUSHED;
                    end else begin
                        n_phase   = PH_WORK;
                        n_exp_seq = seq_sum;
                    end
                end else if (r_phase == PH_SYNC && !i_req.flag_ack) begin
                    n_phase = PH_INVALID;
                end else begin
                    if (r_phase != PH_WAIT) begin
                        n_fill = '0;
                    end
                    if (i_req.flag_psh) begin
                        n_phase   = PH_SYNC;
                        n_exp_seq = seq_sum;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            end
            MODE_PAYLOAD: begin
                if (r_pending != '0) begin
                    if (r_append && r_fill < CNT_W'(BUF_BYTES)) begin
                        ram_we = accept;
                        n_fill = r_fill + CNT_W'(1);
                    end
                    n_pending = r_pending - LEN_W'(1);
                    if (r_pending == LEN_W'(1)) begin
                        n_append = 1'b0;
                    end
                end
            end
            MODE_READ: begin
                ram_re = accept;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_s1.collector_state = STATE_W'(n_phase);
        n_s1.frame_accepted  = accepted;
        n_s1.message_ready   = (n_phase == PH_PUSHED) && (n_pending == '0);
        n_s1.message_length  = n_fill;
        n_s1.read_hit        = (i_req.mode == MODE_READ)
                            && (CNT_W'(i_req.read_index) < r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INVALID;
            r_fill    <= '0;
            r_exp_seq <= '0;
            r_exp_ack <= '0;
            r_pending <= '0;
            r_append  <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_exp_seq <= n_exp_seq;
            r_exp_ack <= n_exp_ack;
            r_pending <= n_pending;
            r_append  <= n_append;
        end
    end

    tpmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[BUF_AW-1:0]),
        .i_wdata (i_req.data_byte),
        .i_re    (ram_re),
        .i_raddr (BUF_AW'(i_req.read_index)),
        .o_rdata (ram_rdata)
    );

    // hold the read stage while the output register is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out      <= r_s1;
            r_out_byte <= r_s1.read_hit ? ram_rdata : '0;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.collector_state = r_out.collector_state;
    assign o_rsp.frame_accepted  = r_out.frame_accepted;
    assign o_rsp.message_ready   = r_out.message_ready;
    assign o_rsp.message_length  = 13'(r_out.message_length);
    assign o_rsp.read_byte       = r_out_byte;

endmodule

// ===== rtl/tpmc_ram.sv =====
// ----------------------------------------------------------------------------
// tpmc_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
